// ===== hw/rtl/nvs_pkg.sv =====
// Shared types and constants for the nine-value sort core.
package nvs_pkg;

	localparam int unsigned ROWS  = 3;
	localparam int unsigned COUNT = ROWS * ROWS;
	localparam int unsigned WIDTH = 32;
	localparam int unsigned DATA_W = COUNT * WIDTH;

	typedef logic signed [WIDTH-1:0] elem_t;
	typedef logic [COUNT-1:0][WIDTH-1:0] vec_t;

	// one beat in flight through the network, with its sort direction
	typedef struct packed {
		logic desc;
		vec_t vals;
	} beat_t;

endpackage

// ===== hw/rtl/nvs_cmp_lane.sv =====
// Compare-exchange lane: puts the value that belongs first on first_val.
module nvs_cmp_lane
	import nvs_pkg::*;
(
	input  logic  desc,
	input  elem_t a_val,
	input  elem_t b_val,
	output elem_t first_val,
	output elem_t second_val
);

	logic swap;

	always_comb begin
		if (desc) begin
			swap = (a_val < b_val);
		end else begin
			swap = (a_val > b_val);
		end
		first_val  = swap ? b_val : a_val;
		second_val = swap ? a_val : b_val;
	end

endmodule

// ===== hw/rtl/nvs_stage.sv =====
// One odd-even transposition stage: parallel compare lanes and a stage register.
module nvs_stage
	import nvs_pkg::*;
#(
	parameter int unsigned PHASE = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  beat_t in_beat,
	output logic  out_valid,
	input  logic  out_ready,
	output beat_t out_beat
);

	vec_t  nxt;
	logic  valid_q;
	beat_t beat_q;

	for (genvar p = 0; p < COUNT; p++) begin : g_elem
		if (p >= PHASE && ((p - PHASE) % 2 == 0) && (p + 1 < COUNT)) begin : g_lane
			elem_t lo_val;
			elem_t hi_val;
			nvs_cmp_lane u_lane (
				.desc       (in_beat.desc),
				.a_val      (elem_t'(in_beat.vals[p])),
				.b_val      (elem_t'(in_beat.vals[p+1])),
				.first_val  (lo_val),
				.second_val (hi_val)
			);
			assign nxt[p]   = lo_val;
			assign nxt[p+1] = hi_val;
		end else if (p < PHASE || (((p - PHASE) % 2 == 0) && (p + 1 >= COUNT))) begin : g_pass
			assign nxt[p] = in_beat.vals[p];
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_q.desc <= in_beat.desc;
			beat_q.vals <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_beat  = beat_q;

endmodule

// ===== hw/rtl/nine_value_sort_core.sv =====
// Nine-value sort core: sorts the nine elements of a 3x3 matrix each beat.
//
// Input channel s_*: one beat carries the nine signed 32-bit elements,
// row-major, element r0c0 in the lowest 32 bits of s_tdata.
// Output channel m_*: one beat carries the nine values in sorted order,
// out_0 in the lowest 32 bits of m_tdata; out_4 is the median.
// cfg_we/cfg_wdata set the direction: 0 smallest first, 1 largest first.
// The direction is sampled with each input beat and travels with it.
//
// From input accept to output valid a beat passes one register per
// transposition stage, four compare lanes per stage.
// Throughput is one beat per cycle while m_tready is high. Each stage has its own
// valid and ready, so a stalled receiver holds only the last full stage and
// bubbles behind it still fill; s_tready drops once all nine stages are full.
// Reset clears every stage's valid bit and sets ascending order.
module nine_value_sort_core
	import nvs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // in_r0c0..in_r2c2, 32 bits each
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,  // out_0..out_8, 32 bits each
	input  logic              cfg_we,
	input  logic              cfg_wdata
);

	logic  descending_q;
	logic  valid   [COUNT+1];
	logic  ready   [COUNT+1];
	beat_t beat    [COUNT+1];
	logic  sorted_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
		end else if (cfg_we) begin
			descending_q <= cfg_wdata;
		end
	end

	assign valid[0]     = s_tvalid;
	assign s_tready     = ready[0];
	assign beat[0].desc = descending_q;
	assign beat[0].vals = vec_t'(s_tdata);

	for (genvar k = 0; k < COUNT; k++) begin : g_stage
		nvs_stage #(
			.PHASE (k % 2)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[k]),
			.in_ready  (ready[k]),
			.in_beat   (beat[k]),
			.out_valid (valid[k+1]),
			.out_ready (ready[k+1]),
			.out_beat  (beat[k+1])
		);
	end

	assign ready[COUNT] = m_tready;
	assign m_tvalid     = valid[COUNT];
	assign m_tdata      = beat[COUNT].vals;

	always_comb begin
		sorted_ok = 1'b1;
		for (int i = 0; i < COUNT - 1; i++) begin
			if (beat[COUNT].desc) begin
				if (elem_t'(beat[COUNT].vals[i]) < elem_t'(beat[COUNT].vals[i+1])) begin
					sorted_ok = 1'b0;
				end
			end else begin
				if (elem_t'(beat[COUNT].vals[i]) > elem_t'(beat[COUNT].vals[i+1])) begin
					sorted_ok = 1'b0;
				end
			end
		end
	end

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> sorted_ok)
		else $error("output beat not in sorted order");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input held off without an output stall");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input not ready while output stage is empty");

endmodule
